>>> rtl/core/stq_pkg.sv
// ----------------------------------------------------------------------------
// Sorted timer queue package
// Shared widths, command and status codes, and the types that pass between
// the top level and the list cells.
// ----------------------------------------------------------------------------
package stq_pkg;

    localparam int SLOT_W         = 4;
    localparam int CMD_W          = 2;
    localparam int STAT_W         = 3;
    localparam int TAG_W          = 8;
    localparam int WORD_W         = 32;
    localparam int CNT_OUT_W      = 5;
    localparam int NUM_TIMERS_DEF = 16;
    localparam int TIME_BITS_DEF  = 32;

    typedef enum logic [CMD_W-1:0] {
        CMD_INSERT  = 2'd0,
        CMD_DEQUEUE = 2'd1,
        CMD_REMOVE  = 2'd2,
        CMD_QUERY   = 2'd3
    } t_cmd;

    typedef enum logic [STAT_W-1:0] {
        STS_OK          = 3'd0,
        STS_BAD_TIMEOUT = 3'd1,
        STS_SLOT_BUSY   = 3'd2,
        STS_EMPTY       = 3'd3,
        STS_NOT_PENDING = 3'd4
    } t_status;

    // Everything a list entry holds apart from its deadline.
    typedef struct packed {
        logic              valid;
        logic [SLOT_W-1:0] slot;
        logic [TAG_W-1:0]  owner;
        logic [TAG_W-1:0]  handler;
    } t_tag;

    // Operation broadcast to every cell of the chain.
    typedef struct packed {
        logic              do_insert;
        logic              do_pop;
        logic              do_remove;
        logic [SLOT_W-1:0] key_slot;
        t_tag              new_tag;
    } t_cell_ctl;

endpackage

>>> rtl/core/stq_ifs.sv
// ----------------------------------------------------------------------------
// Sorted timer queue channels
// Valid/ready channels for command transactions and result transactions.
// ----------------------------------------------------------------------------
interface stq_in_if;
    logic                             valid;
    logic                             ready;
    logic [stq_pkg::CMD_W-1:0]        command;
    logic [stq_pkg::SLOT_W-1:0]       slot;
    logic [stq_pkg::WORD_W-1:0]       now;
    logic signed [stq_pkg::WORD_W-1:0] timeout;
    logic [stq_pkg::TAG_W-1:0]        owner;
    logic [stq_pkg::TAG_W-1:0]        handler;

    modport source (output valid, command, slot, now, timeout, owner, handler,
                    input ready);
    modport sink   (input valid, command, slot, now, timeout, owner, handler,
                    output ready);
endinterface

interface stq_out_if;
    logic                          valid;
    logic                          ready;
    logic [stq_pkg::STAT_W-1:0]    status;
    logic [stq_pkg::SLOT_W-1:0]    out_slot;
    logic [stq_pkg::TAG_W-1:0]     out_owner;
    logic [stq_pkg::TAG_W-1:0]     out_handler;
    logic [stq_pkg::WORD_W-1:0]    out_deadline;
    logic [stq_pkg::WORD_W-1:0]    next_deadline;
    logic [stq_pkg::CNT_OUT_W-1:0] pending_count;

    modport source (output valid, status, out_slot, out_owner, out_handler,
                    out_deadline, next_deadline, pending_count, input ready);
    modport sink   (input valid, status, out_slot, out_owner, out_handler,
                    out_deadline, next_deadline, pending_count, output ready);
endinterface

>>> rtl/core/sorted_timer_queue_top.sv
// A command transaction passes through capture, deadline add, list update and
// result before its result transaction appears.
// One command is handled at a time; the list cells take one update per
// command and the next command is taken once the current result has moved into
// the result register, so a held result stalls the command channel.
// Reset empties the list (all cell valid bits cleared, count 0);
// there is no clearing pass.
// ----------------------------------------------------------------------------
// Sorted timer queue top level
// Timer slots kept in a chain of cells sorted by deadline, earliest at cell 0.
// ----------------------------------------------------------------------------
module sorted_timer_queue_top #(
    parameter int NUM_TIMERS = stq_pkg::NUM_TIMERS_DEF,
    parameter int TIME_BITS  = stq_pkg::TIME_BITS_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    stq_in_if.sink     i_cmd,
    stq_out_if.source  o_res
);
    import stq_pkg::*;

    localparam int CNT_W = $clog2(NUM_TIMERS + 1);
    localparam int SUM_W = (TIME_BITS > WORD_W ? TIME_BITS : WORD_W) + 1;
    localparam logic [TIME_BITS-1:0] NEVER = {TIME_BITS{1'b1}};

    typedef enum logic [1:0] {
        S_IDLE,
        S_DEADLINE,
        S_APPLY,
        S_RESULT
    } t_state;

    t_state               r_state;
    t_cmd                 r_cmd;
    logic [SLOT_W-1:0]    r_slot;
    logic [TIME_BITS-1:0] r_now;
    logic [WORD_W-1:0]    r_timeout;
    logic [TAG_W-1:0]     r_owner;
    logic [TAG_W-1:0]     r_handler;
    logic [TIME_BITS-1:0] r_dl;
    logic [CNT_W-1:0]     r_count;

    t_status              r_res_status;
    logic [SLOT_W-1:0]    r_res_slot;
    logic [TAG_W-1:0]     r_res_owner;
    logic [TAG_W-1:0]     r_res_handler;
    logic [WORD_W-1:0]    r_res_dl;

    logic                 r_out_valid;
    logic [STAT_W-1:0]    r_out_status;
    logic [SLOT_W-1:0]    r_out_slot;
    logic [TAG_W-1:0]     r_out_owner;
    logic [TAG_W-1:0]     r_out_handler;
    logic [WORD_W-1:0]    r_out_dl;
    logic [WORD_W-1:0]    r_out_next_dl;
    logic [CNT_OUT_W-1:0] r_out_count;

    logic [SUM_W-1:0]     dl_sum;
    logic [TIME_BITS-1:0] dl_sat;
    logic                 bad_timeout;
    logic                 slot_in_range;
    logic                 list_full;
    logic                 hit;
    logic                 ins_ok;
    logic                 pop_ok;
    logic                 rm_ok;
    t_status              status;
    t_cell_ctl            ctl;

    logic [TIME_BITS-1:0] dl_w    [NUM_TIMERS];
    t_tag                 tag_w   [NUM_TIMERS];
    logic                 keep_w  [NUM_TIMERS];
    logic                 found_w [NUM_TIMERS];
    logic [NUM_TIMERS-1:0] valid_vec;

    // Deadline = now + timeout, held below the never value.
    assign dl_sum = SUM_W'(r_now) + SUM_W'(r_timeout[WORD_W-2:0]);
    assign dl_sat = (dl_sum >= SUM_W'(NEVER)) ? (NEVER - 1'b1) : dl_sum[TIME_BITS-1:0];

    assign bad_timeout   = (r_timeout == '0) || r_timeout[WORD_W-1];
    assign slot_in_range = (int'(r_slot) < NUM_TIMERS);
    assign list_full     = (r_count >= CNT_W'(NUM_TIMERS));
    // A slot is busy exactly when some cell holds it.
    assign hit           = found_w[NUM_TIMERS-1];

    assign ins_ok = (r_cmd == CMD_INSERT) && !bad_timeout && slot_in_range
                    && !hit && !list_full;
    assign pop_ok = (r_cmd == CMD_DEQUEUE) && (r_count != '0);
    assign rm_ok  = (r_cmd == CMD_REMOVE) && hit;

    always_comb begin
        unique case (r_cmd)
            CMD_INSERT: begin
                if (bad_timeout) begin
                    status = STS_BAD_TIMEOUT;
                end else if (!slot_in_range || hit || list_full) begin
                    status = STS_SLOT_BUSY;
                end else begin
                    status = STS_OK;
                end
            end
            CMD_DEQUEUE: status = (r_count == '0) ? STS_EMPTY : STS_OK;
            CMD_REMOVE:  status = hit ? STS_OK : STS_NOT_PENDING;
            default:     status = STS_OK;
        endcase
    end

    always_comb begin
        ctl.do_insert       = (r_state == S_APPLY) && ins_ok;
        ctl.do_pop          = (r_state == S_APPLY) && pop_ok;
        ctl.do_remove       = (r_state == S_APPLY) && rm_ok;
        ctl.key_slot        = r_slot;
        ctl.new_tag.valid   = 1'b1;
        ctl.new_tag.slot    = r_slot;
        ctl.new_tag.owner   = r_owner;
        ctl.new_tag.handler = r_handler;
    end

    for (genvar i = 0; i < NUM_TIMERS; i++) begin : g_cell
        logic [TIME_BITS-1:0] prev_dl;
        t_tag                 prev_tag;
        logic                 prev_keep;
        logic                 prev_found;
        logic [TIME_BITS-1:0] next_dl;
        t_tag                 next_tag;

        if (i == 0) begin : g_head
            assign prev_dl    = '0;
            assign prev_tag   = '0;
            assign prev_keep  = 1'b1;
            assign prev_found = 1'b0;
        end else begin : g_link
            assign prev_dl    = dl_w[i-1];
            assign prev_tag   = tag_w[i-1];
            assign prev_keep  = keep_w[i-1];
            assign prev_found = found_w[i-1];
        end

        if (i == NUM_TIMERS - 1) begin : g_tail
            assign next_dl  = '0;
            assign next_tag = '0;
        end else begin : g_body
            assign next_dl  = dl_w[i+1];
            assign next_tag = tag_w[i+1];
        end

        stq_cell #(
            .TIME_BITS (TIME_BITS)
        ) u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_ctl        (ctl),
            .i_key_dl     (r_dl),
            .i_prev_dl    (prev_dl),
            .i_prev_tag   (prev_tag),
            .i_prev_keep  (prev_keep),
            .i_prev_found (prev_found),
            .i_next_dl    (next_dl),
            .i_next_tag   (next_tag),
            .o_dl         (dl_w[i]),
            .o_tag        (tag_w[i]),
            .o_keep       (keep_w[i]),
            .o_found      (found_w[i])
        );

        assign valid_vec[i] = tag_w[i].valid;
    end

    assign i_cmd.ready         = (r_state == S_IDLE);
    assign o_res.valid         = r_out_valid;
    assign o_res.status        = r_out_status;
    assign o_res.out_slot      = r_out_slot;
    assign o_res.out_owner     = r_out_owner;
    assign o_res.out_handler   = r_out_handler;
    assign o_res.out_deadline  = r_out_dl;
    assign o_res.next_deadline = r_out_next_dl;
    assign o_res.pending_count = r_out_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            // In the result state the register is either reloaded or still held.
            if (r_out_valid && o_res.ready && (r_state != S_RESULT)) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_cmd.valid) begin
                        r_cmd     <= t_cmd'(i_cmd.command);
                        r_slot    <= i_cmd.slot;
                        r_now     <= TIME_BITS'(i_cmd.now);
                        r_timeout <= i_cmd.timeout;
                        r_owner   <= i_cmd.owner;
                        r_handler <= i_cmd.handler;
                        r_state   <= S_DEADLINE;
                    end
                end
                S_DEADLINE: begin
                    r_dl    <= dl_sat;
                    r_state <= S_APPLY;
                end
                S_APPLY: begin
                    r_res_status  <= status;
                    r_res_slot    <= pop_ok ? tag_w[0].slot : r_slot;
                    r_res_owner   <= pop_ok ? tag_w[0].owner : '0;
                    r_res_handler <= pop_ok ? tag_w[0].handler : '0;
                    if (pop_ok) begin
                        r_res_dl <= WORD_W'(dl_w[0]);
                    end else if (ins_ok) begin
                        r_res_dl <= WORD_W'(r_dl);
                    end else begin
                        r_res_dl <= '0;
                    end
                    if (ins_ok) begin
                        r_count <= r_count + 1'b1;
                    end else if (pop_ok || rm_ok) begin
                        r_count <= r_count - 1'b1;
                    end
                    r_state <= S_RESULT;
                end
                S_RESULT: begin
                    // The list already reflects this command, so cell 0 is the new head.
                    if (!r_out_valid || o_res.ready) begin
                        r_out_valid   <= 1'b1;
                        r_out_status  <= r_res_status;
                        r_out_slot    <= r_res_slot;
                        r_out_owner   <= r_res_owner;
                        r_out_handler <= r_res_handler;
                        r_out_dl      <= r_res_dl;
                        r_out_next_dl <= tag_w[0].valid ? WORD_W'(dl_w[0])
                                                        : WORD_W'(NEVER);
                        r_out_count   <= CNT_OUT_W'(r_count);
                        r_state       <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(NUM_TIMERS))
        else $error("pending count above the number of timers");

    a_count_matches_cells: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(valid_vec) == int'(r_count))
        else $error("pending count differs from occupied cells");

    a_head_sorted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        tag_w[1].valid |-> (tag_w[0].valid && (dl_w[0] <= dl_w[1])))
        else $error("head of list not earliest");

    a_pop_shrinks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ctl.do_pop |=> (r_count == $past(r_count) - 1'b1))
        else $error("dequeue did not shrink the list");

endmodule

>>> rtl/core/stq_cell.sv
// ----------------------------------------------------------------------------
// Sorted timer queue cell
// Holds one position of the sorted list and moves its entry to or from its
// neighbors on insert, pop and remove.
// ----------------------------------------------------------------------------
module stq_cell #(
    parameter int TIME_BITS = stq_pkg::TIME_BITS_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  stq_pkg::t_cell_ctl     i_ctl,
    input  logic [TIME_BITS-1:0]   i_key_dl,
    input  logic [TIME_BITS-1:0]   i_prev_dl,
    input  stq_pkg::t_tag          i_prev_tag,
    input  logic                   i_prev_keep,
    input  logic                   i_prev_found,
    input  logic [TIME_BITS-1:0]   i_next_dl,
    input  stq_pkg::t_tag          i_next_tag,
    output logic [TIME_BITS-1:0]   o_dl,
    output stq_pkg::t_tag          o_tag,
    output logic                   o_keep,
    output logic                   o_found
);
    import stq_pkg::*;

    logic [TIME_BITS-1:0] r_dl;
    logic [TIME_BITS-1:0] n_dl;
    t_tag                 r_tag;
    t_tag                 n_tag;
    logic                 match;

    assign match   = r_tag.valid && (r_tag.slot == i_ctl.key_slot);
    // Equal deadlines stay ahead of a new entry, so later inserts queue behind.
    assign o_keep  = r_tag.valid && (r_dl <= i_key_dl);
    assign o_found = i_prev_found || match;
    assign o_dl    = r_dl;
    assign o_tag   = r_tag;

    always_comb begin
        n_dl  = r_dl;
        n_tag = r_tag;
        if (i_ctl.do_insert) begin
            if (!o_keep) begin
                if (i_prev_keep) begin
                    n_dl  = i_key_dl;
                    n_tag = i_ctl.new_tag;
                end else begin
                    n_dl  = i_prev_dl;
                    n_tag = i_prev_tag;
                end
            end
        end else if (i_ctl.do_pop || (i_ctl.do_remove && o_found)) begin
            n_dl  = i_next_dl;
            n_tag = i_next_tag;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tag <= '0;
            r_dl  <= '0;
        end else begin
            r_tag <= n_tag;
            r_dl  <= n_dl;
        end
    end

endmodule

>>> dv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sorted timer queue testbench
// Sends insert, dequeue, remove and query transactions through the command
// channel and checks every result transaction against a timer list kept in
// the bench. A short directed part covers the corner cases, then a long
// random part alternates fill and drain phases so the list runs full and
// empty many times. Both channels idle at random.
// ----------------------------------------------------------------------------
module tb_top;
    import stq_pkg::*;

    localparam int                SLOTS       = NUM_TIMERS_DEF;
    localparam logic [WORD_W-1:0] NEVER       = '1;
    localparam int                RANDOM_CMDS = 1300;
    localparam int                CYCLE_LIMIT = 600000;
    localparam int                LONG_HOLD   = 400;

    typedef struct packed {
        logic                drain_first;
        t_cmd                command;
        logic [SLOT_W-1:0]   slot;
        logic [WORD_W-1:0]   now;
        logic [WORD_W-1:0]   timeout;
        logic [TAG_W-1:0]    owner;
        logic [TAG_W-1:0]    handler;
    } t_timer_cmd;

    typedef struct packed {
        t_status              status;
        logic [SLOT_W-1:0]    slot;
        logic [TAG_W-1:0]     owner;
        logic [TAG_W-1:0]     handler;
        logic [WORD_W-1:0]    deadline;
        logic [WORD_W-1:0]    next_deadline;
        logic [CNT_OUT_W-1:0] count;
    } t_timer_result;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    stq_in_if  cmd_if ();
    stq_out_if res_if ();

    sorted_timer_queue_top u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd_if),
        .o_res   (res_if)
    );

    always #6 i_clk = ~i_clk;

    // Timer list as the bench sees it: slot order earliest first plus slot data.
    logic [SLOT_W-1:0] list_order [SLOTS];
    int                list_len = 0;
    logic [WORD_W-1:0] slot_dl [SLOTS];
    logic [TAG_W-1:0]  slot_owner [SLOTS];
    logic [TAG_W-1:0]  slot_handler [SLOTS];
    bit                slot_live [SLOTS];

    t_timer_cmd    pending_cmds [$];
    t_timer_result expected_results [$];

    t_timer_cmd cur_cmd;
    bit         offering = 1'b0;
    int         send_gap = 0;
    int         send_calm = 0;
    int         recv_calm = 0;
    int         recv_stall = 0;
    int         recv_taken = 0;
    bit         long_hold_done = 1'b0;
    int         mismatch_count = 0;
    int         results_seen = 0;
    int         cycle_count = 0;

    function automatic void drop_entry(input int pos);
        int i;
        for (i = pos; i + 1 < list_len; i++)
            list_order[i] = list_order[i + 1];
        list_len--;
    endfunction

    function automatic t_timer_result apply_timer_cmd(input t_timer_cmd c);
        t_timer_result     r;
        logic [WORD_W:0]   sum;
        logic [WORD_W-1:0] dl;
        logic [SLOT_W-1:0] head;
        int                pos;
        int                i;
        r        = '0;
        r.status = STS_OK;
        r.slot   = c.slot;
        case (c.command)
            CMD_INSERT: begin
                if (c.timeout == '0 || c.timeout[WORD_W-1]) begin
                    r.status = STS_BAD_TIMEOUT;
                end else if (slot_live[c.slot] || list_len >= SLOTS) begin
                    r.status = STS_SLOT_BUSY;
                end else begin
                    // The deadline saturates one tick below the never value.
                    sum = {1'b0, c.now} + {1'b0, c.timeout};
                    dl  = (sum >= {1'b0, NEVER}) ? NEVER - 1 : sum[WORD_W-1:0];
                    pos = 0;
                    while (pos < list_len && slot_dl[list_order[pos]] <= dl)
                        pos++;
                    for (i = list_len; i > pos; i--)
                        list_order[i] = list_order[i - 1];
                    list_order[pos]      = c.slot;
                    list_len++;
                    slot_live[c.slot]    = 1'b1;
                    slot_dl[c.slot]      = dl;
                    slot_owner[c.slot]   = c.owner;
                    slot_handler[c.slot] = c.handler;
                    r.deadline           = dl;
                end
            end
            CMD_DEQUEUE: begin
                if (list_len == 0) begin
                    r.status = STS_EMPTY;
                end else begin
                    head            = list_order[0];
                    r.slot          = head;
                    r.owner         = slot_owner[head];
                    r.handler       = slot_handler[head];
                    r.deadline      = slot_dl[head];
                    slot_live[head] = 1'b0;
                    drop_entry(0);
                end
            end
            CMD_REMOVE: begin
                if (!slot_live[c.slot]) begin
                    r.status = STS_NOT_PENDING;
                end else begin
                    pos = 0;
                    while (pos < list_len && list_order[pos] != c.slot)
                        pos++;
                    if (pos < list_len)
                        drop_entry(pos);
                    slot_live[c.slot] = 1'b0;
                end
            end
            default: ;
        endcase
        r.next_deadline = (list_len == 0) ? NEVER : slot_dl[list_order[0]];
        r.count         = list_len[CNT_OUT_W-1:0];
        return r;
    endfunction

    function automatic t_timer_cmd make_cmd(input t_cmd cmd, input int slot,
                                            input logic [WORD_W-1:0] now,
                                            input logic [WORD_W-1:0] timeout,
                                            input int owner, input int handler);
        t_timer_cmd c;
        c.drain_first = 1'b0;
        c.command     = cmd;
        c.slot        = slot[SLOT_W-1:0];
        c.now         = now;
        c.timeout     = timeout;
        c.owner       = owner[TAG_W-1:0];
        c.handler     = handler[TAG_W-1:0];
        return c;
    endfunction

    // Mostly short gaps, a few long ones, and now and then a run with none.
    function automatic int pick_gap(inout int calm);
        int r;
        if (calm > 0) begin
            calm--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 3) begin
            calm = $urandom_range(20, 60);
            return 0;
        end
        if (r < 55)
            return 0;
        if (r < 88)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 40);
    endfunction

    task automatic check_field(input string fname, input logic [WORD_W-1:0] got,
                               input logic [WORD_W-1:0] want);
        if (got !== want) begin
            mismatch_count++;
            if (mismatch_count <= 10)
                $display("mismatch in %s at result %0d: expected %h, got %h",
                         fname, results_seen, want, got);
        end
    endtask

    // Driver: one command transaction at a time, taken from pending_cmds.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            offering     = 1'b0;
            cmd_if.valid <= 1'b0;
        end else begin
            if (cmd_if.valid && cmd_if.ready) begin
                expected_results.push_back(apply_timer_cmd(cur_cmd));
                offering = 1'b0;
                send_gap = pick_gap(send_calm);
            end
            if (!offering) begin
                if (send_gap > 0) begin
                    send_gap--;
                end else if (pending_cmds.size() != 0 &&
                             (!pending_cmds[0].drain_first ||
                              expected_results.size() == 0)) begin
                    cur_cmd  = pending_cmds.pop_front();
                    offering = 1'b1;
                end
            end
            cmd_if.valid   <= offering;
            cmd_if.command <= cur_cmd.command;
            cmd_if.slot    <= cur_cmd.slot;
            cmd_if.now     <= cur_cmd.now;
            cmd_if.timeout <= cur_cmd.timeout;
            cmd_if.owner   <= cur_cmd.owner;
            cmd_if.handler <= cur_cmd.handler;
        end
    end

    // Result side back-pressure, with one long hold-off to fill the block.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            res_if.ready <= 1'b0;
        end else begin
            if (res_if.valid && res_if.ready) begin
                recv_taken++;
                recv_stall = pick_gap(recv_calm);
                if (!long_hold_done && recv_taken == 200) begin
                    recv_stall     = LONG_HOLD;
                    long_hold_done = 1'b1;
                end
            end else if (recv_stall > 0) begin
                recv_stall--;
            end
            res_if.ready <= (recv_stall == 0);
        end
    end

    // Monitor: each result transaction against the oldest expectation.
    always @(posedge i_clk) begin
        t_timer_result want;
        if (i_rst_n && res_if.valid && res_if.ready) begin
            results_seen++;
            if (expected_results.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("result %0d arrived with nothing expected", results_seen);
            end else begin
                want = expected_results.pop_front();
                check_field("status", WORD_W'(res_if.status), WORD_W'(want.status));
                check_field("out_slot", WORD_W'(res_if.out_slot), WORD_W'(want.slot));
                check_field("out_owner", WORD_W'(res_if.out_owner), WORD_W'(want.owner));
                check_field("out_handler", WORD_W'(res_if.out_handler),
                            WORD_W'(want.handler));
                check_field("out_deadline", res_if.out_deadline, want.deadline);
                check_field("next_deadline", res_if.next_deadline, want.next_deadline);
                check_field("pending_count", WORD_W'(res_if.pending_count),
                            WORD_W'(want.count));
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("run timed out after %0d cycles", cycle_count);
            $display("** sorted_timer_queue_top: FAILED **");
            $finish;
        end
    end

    initial begin
        t_timer_cmd        c;
        t_cmd              cmd;
        logic [WORD_W-1:0] base_now;
        logic [WORD_W-1:0] now;
        logic [WORD_W-1:0] timeout;
        bit                filling;
        int                phase_left;
        int                r;
        int                n;

        // Directed corner cases.
        pending_cmds.push_back(make_cmd(CMD_DEQUEUE, 5, 0, 1, 0, 0));
        pending_cmds.push_back(make_cmd(CMD_REMOVE, 3, 0, 1, 0, 0));
        pending_cmds.push_back(make_cmd(CMD_QUERY, 15, '1, '1, 255, 255));
        pending_cmds.push_back(make_cmd(CMD_INSERT, 0, 100, 0, 1, 1));
        pending_cmds.push_back(make_cmd(CMD_INSERT, 0, 100, 32'h8000_0000, 1, 1));
        pending_cmds.push_back(make_cmd(CMD_INSERT, 0, 100, 32'hFFFF_FFFF, 1, 1));
        pending_cmds.push_back(make_cmd(CMD_INSERT, 0, '1, 1, 255, 255));
        pending_cmds.push_back(make_cmd(CMD_INSERT, 1, 0, 32'h7FFF_FFFF, 0, 0));
        pending_cmds.push_back(make_cmd(CMD_INSERT, 2, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                                        17, 34));
        pending_cmds.push_back(make_cmd(CMD_INSERT, 0, 5, 5, 2, 2));
        pending_cmds.push_back(make_cmd(CMD_INSERT, 3, 100, 1, 3, 30));
        pending_cmds.push_back(make_cmd(CMD_INSERT, 4, 100, 1, 4, 40));
        pending_cmds.push_back(make_cmd(CMD_INSERT, 15, 32'h8000_0000, 32'h7FFF_FFFF,
                                        255, 0));
        pending_cmds.push_back(make_cmd(CMD_REMOVE, 4, 0, 0, 0, 0));
        pending_cmds.push_back(make_cmd(CMD_REMOVE, 4, 0, 0, 0, 0));
        pending_cmds.push_back(make_cmd(CMD_DEQUEUE, 0, 0, 0, 0, 0));
        pending_cmds.push_back(make_cmd(CMD_REMOVE, 2, 0, 0, 0, 0));
        pending_cmds.push_back(make_cmd(CMD_QUERY, 0, 0, 0, 0, 0));
        for (n = 0; n < 4; n++)
            pending_cmds.push_back(make_cmd(CMD_DEQUEUE, 15, 0, 0, 0, 0));

        // Random part: alternating fill and drain phases.
        base_now   = $urandom;
        filling    = 1'b1;
        phase_left = 0;
        for (n = 0; n < RANDOM_CMDS; n++) begin
            if (phase_left == 0) begin
                filling    = !filling;
                phase_left = $urandom_range(10, 60);
            end
            phase_left--;
            r = $urandom_range(0, 99);
            if (filling)
                cmd = (r < 70) ? CMD_INSERT : (r < 85) ? CMD_DEQUEUE :
                      (r < 97) ? CMD_REMOVE : CMD_QUERY;
            else
                cmd = (r < 20) ? CMD_INSERT : (r < 65) ? CMD_DEQUEUE :
                      (r < 97) ? CMD_REMOVE : CMD_QUERY;

            // Clustered times make equal deadlines common.
            base_now = base_now + $urandom_range(0, 3);
            r = $urandom_range(0, 99);
            if (r < 60)
                now = base_now;
            else if (r < 70)
                now = NEVER - $urandom_range(0, 64);
            else
                now = $urandom;

            r = $urandom_range(0, 99);
            if (r < 3)
                timeout = '0;
            else if (r < 8)
                timeout = $urandom | 32'h8000_0000;
            else if (r < 58)
                timeout = $urandom_range(1, 8);
            else if (r < 88)
                timeout = $urandom_range(1, 32'h7FFF_FFFF);
            else
                timeout = 32'h7FFF_FFFF - $urandom_range(0, 3);

            c = make_cmd(cmd, $urandom_range(0, SLOTS - 1), now, timeout,
                         $urandom_range(0, 255), $urandom_range(0, 255));
            // Let the block run dry now and then before going on.
            c.drain_first = (n % 300 == 0);
            pending_cmds.push_back(c);
        end

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (pending_cmds.size() != 0 || offering)
            @(posedge i_clk);
        while (expected_results.size() != 0)
            @(posedge i_clk);
        repeat (12) @(posedge i_clk);

        if (mismatch_count == 0)
            $display("** sorted_timer_queue_top: PASSED **");
        else
            $display("** sorted_timer_queue_top: FAILED **");
        $finish;
    end

endmodule
